// File: rtl/isothermal_sphere_lens_terms_macros.svh
// Assertion helpers; clk and arst_n must be in scope at the point of use.
`ifndef ISOTHERMAL_SPHERE_LENS_TERMS_MACROS_SVH
`define ISOTHERMAL_SPHERE_LENS_TERMS_MACROS_SVH

`define ISL_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isl: implication check failed");

`define ISL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isl: next-cycle check failed");

`endif

// File: rtl/isl_pkg.sv
`timescale 1ns / 1ps

package isl_pkg;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned B_W        = 31;
	localparam int unsigned ROOT_W     = 32;
	localparam int unsigned SQ_W       = 2 * DATA_W;
	localparam int unsigned SQRT_REM_W = ROOT_W + 1;
	localparam int unsigned REM_W      = ROOT_W + 1;
	localparam int unsigned PROD_W     = B_W + DATA_W;
	localparam int unsigned QUO_W      = B_W;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned HQUO_W     = QUO_W + FRAC_W;
	localparam int unsigned POT_W      = PROD_W - FRAC_W;
	localparam int unsigned TERM_W     = HQUO_W + 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned N_ACC      = 6;

	localparam logic [CFG_IDX_W-1:0] REG_EINSTEIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRAD_ONLY = 3'd3;

	localparam logic [B_W-1:0] EINSTEIN_RESET = 31'd65536;

	localparam int unsigned ACC_POT = 0;
	localparam int unsigned ACC_GX  = 1;
	localparam int unsigned ACC_GY  = 2;
	localparam int unsigned ACC_HXX = 3;
	localparam int unsigned ACC_HYY = 4;
	localparam int unsigned ACC_HXY = 5;

	// everything that rides alongside the arithmetic cells
	typedef struct packed {
		logic [N_ACC-1:0][DATA_W-1:0] acc;
		logic                         dx_neg;
		logic                         dy_neg;
		logic                         sat;
		logic                         last;
		logic                         zero;
		logic [DATA_W-1:0]            ax;
		logic [DATA_W-1:0]            ay;
		logic [ROOT_W-1:0]            r;
		logic [POT_W-1:0]             pot;
		logic [QUO_W-1:0]             gx;
		logic [QUO_W-1:0]             gy;
	} side_t;

	localparam int unsigned SIDE_W = $bits(side_t);

	typedef struct packed {
		logic                     sat;
		logic [DATA_W-1:0]        val;
	} sum_t;

	function automatic sum_t sub_clamp(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		logic [DATA_W:0] d;
		sum_t            r;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] == d[DATA_W-1]) begin
			r.sat = 1'b0;
			r.val = d[DATA_W-1:0];
		end else begin
			r.sat = 1'b1;
			r.val = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic sum_t clamp_add(input logic [DATA_W-1:0] acc,
		input logic [TERM_W-1:0] term);
		logic [TERM_W:0] s;
		sum_t            r;
		s = {{(TERM_W+1-DATA_W){acc[DATA_W-1]}}, acc} + {term[TERM_W-1], term};
		if (s[TERM_W:DATA_W-1] == '0 || s[TERM_W:DATA_W-1] == '1) begin
			r.sat = 1'b0;
			r.val = s[DATA_W-1:0];
		end else begin
			r.sat = 1'b1;
			r.val = s[TERM_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// File: rtl/isl_sqrt_cell.sv
`timescale 1ns / 1ps

// one root bit per cell: two radicand bits in, trial subtract
module isl_sqrt_cell (
	input  logic                            clk,
	input  logic [isl_pkg::SQRT_REM_W-1:0]  rem_i,
	input  logic [isl_pkg::ROOT_W-1:0]      root_i,
	input  logic [isl_pkg::SQ_W-1:0]        rad_i,
	output logic [isl_pkg::SQRT_REM_W-1:0]  rem_o,
	output logic [isl_pkg::ROOT_W-1:0]      root_o,
	output logic [isl_pkg::SQ_W-1:0]        rad_o
);

	logic [isl_pkg::SQRT_REM_W+1:0] t;
	logic [isl_pkg::SQRT_REM_W+1:0] trial;
	logic [isl_pkg::SQRT_REM_W+1:0] diff;
	logic                           ge;
	logic [isl_pkg::SQRT_REM_W-1:0] rem_q;
	logic [isl_pkg::ROOT_W-1:0]     root_q;
	logic [isl_pkg::SQ_W-1:0]       rad_q;

	always_comb begin
		t     = {rem_i, rad_i[isl_pkg::SQ_W-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		diff  = t - trial;
		ge    = (t >= trial);
	end

	always_ff @(posedge clk) begin
		rem_q  <= ge ? diff[isl_pkg::SQRT_REM_W-1:0] : t[isl_pkg::SQRT_REM_W-1:0];
		root_q <= {root_i[isl_pkg::ROOT_W-2:0], ge};
		rad_q  <= {rad_i[isl_pkg::SQ_W-3:0], 2'b00};
	end

	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign rad_o  = rad_q;

endmodule

// File: rtl/isl_div_cell.sv
`timescale 1ns / 1ps

// one restoring division step; dividend bits shift out as quotient bits shift in
module isl_div_cell #(
	parameter int unsigned QW = isl_pkg::QUO_W
) (
	input  logic                       clk,
	input  logic [isl_pkg::REM_W-1:0]  rem_i,
	input  logic [QW-1:0]              dq_i,
	input  logic [isl_pkg::ROOT_W-1:0] d_i,
	output logic [isl_pkg::REM_W-1:0]  rem_o,
	output logic [QW-1:0]              dq_o,
	output logic [isl_pkg::ROOT_W-1:0] d_o
);

	logic [isl_pkg::REM_W:0]    t;
	logic [isl_pkg::REM_W:0]    dvs;
	logic [isl_pkg::REM_W:0]    diff;
	logic                       ge;
	logic [isl_pkg::REM_W-1:0]  rem_q;
	logic [QW-1:0]              dq_q;
	logic [isl_pkg::ROOT_W-1:0] d_q;

	always_comb begin
		t    = {rem_i, dq_i[QW-1]};
		dvs  = {2'b00, d_i};
		diff = t - dvs;
		ge   = (t >= dvs);
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? diff[isl_pkg::REM_W-1:0] : t[isl_pkg::REM_W-1:0];
		dq_q  <= {dq_i[QW-2:0], ge};
		d_q   <= d_i;
	end

	assign rem_o = rem_q;
	assign dq_o  = dq_q;
	assign d_o   = d_q;

endmodule

// File: rtl/isl_div_chain.sv
`timescale 1ns / 1ps

// QW cells, one quotient bit each; needs rem_i < d_i on entry
module isl_div_chain #(
	parameter int unsigned QW = isl_pkg::QUO_W
) (
	input  logic                       clk,
	input  logic [isl_pkg::REM_W-1:0]  rem_i,
	input  logic [QW-1:0]              dq_i,
	input  logic [isl_pkg::ROOT_W-1:0] d_i,
	output logic [QW-1:0]              q_o
);

	logic [isl_pkg::REM_W-1:0]  rem_w [QW+1];
	logic [QW-1:0]              dq_w  [QW+1];
	logic [isl_pkg::ROOT_W-1:0] d_w   [QW+1];

	assign rem_w[0] = rem_i;
	assign dq_w[0]  = dq_i;
	assign d_w[0]   = d_i;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		isl_div_cell #(.QW(QW)) u_cell (
			.clk   (clk),
			.rem_i (rem_w[i]),
			.dq_i  (dq_w[i]),
			.d_i   (d_w[i]),
			.rem_o (rem_w[i+1]),
			.dq_o  (dq_w[i+1]),
			.d_o   (d_w[i+1])
		);
	end

	assign q_o = dq_w[QW];

endmodule

// File: rtl/isl_delay.sv
`timescale 1ns / 1ps

// side data shift line matching a cell chain
module isl_delay #(
	parameter int unsigned W = isl_pkg::SIDE_W,
	parameter int unsigned N = isl_pkg::QUO_W
) (
	input  logic         clk,
	input  logic [W-1:0] data_i,
	output logic [W-1:0] data_o
);

	logic [W-1:0] stage_q [N];

	always_ff @(posedge clk) begin
		stage_q[0] <= data_i;
		for (int i = 1; i < N; i++) begin
			stage_q[i] <= stage_q[i-1];
		end
	end

	assign data_o = stage_q[N-1];

endmodule

// File: rtl/isothermal_sphere_lens_terms.sv
// Singular isothermal sphere lens terms, signed Q16.16.
// Command channel: drive start with pos_x/pos_y, the six prior sums and last_point;
// a word is taken on a clock edge with start high and busy low. busy is high only
// during the first cycle after reset, then stays low: a word may be taken every cycle.
// Result channel: done pulses for one cycle with pot, grad_*, hess_*, at_center,
// saturated and last_out; the receiver cannot stall and must take it that cycle.
// Pipeline, from the accepting edge to the output register: offset, square, sum,
// 32 square-root cells (two radicand bits each), a multiply, 31 divider cells for
// b*|d|/r, a multiply, 31 cells for u*|q|/r, then 47 cells for v*2^16/r, and the
// output register. Throughput is one word per cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
// Einstein radius, 1 and 2 the lens center, 3 gradient-only mode; other indexes
// are dropped. Write only while no words are in flight.
// Reset clears the registers to b = 1.0, center at origin, full update, and empties
// the pipeline.
`timescale 1ns / 1ps
`include "isothermal_sphere_lens_terms_macros.svh"

module isothermal_sphere_lens_terms (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [isl_pkg::DATA_W-1:0]        pos_x,
	input  logic [isl_pkg::DATA_W-1:0]        pos_y,
	input  logic [isl_pkg::DATA_W-1:0]        acc_pot,
	input  logic [isl_pkg::DATA_W-1:0]        acc_grad_x,
	input  logic [isl_pkg::DATA_W-1:0]        acc_grad_y,
	input  logic [isl_pkg::DATA_W-1:0]        acc_hess_xx,
	input  logic [isl_pkg::DATA_W-1:0]        acc_hess_yy,
	input  logic [isl_pkg::DATA_W-1:0]        acc_hess_xy,
	input  logic                              last_point,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [isl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [isl_pkg::DATA_W-1:0]        cfg_data,
	output logic                              done,
	output logic [isl_pkg::DATA_W-1:0]        pot,
	output logic [isl_pkg::DATA_W-1:0]        grad_x,
	output logic [isl_pkg::DATA_W-1:0]        grad_y,
	output logic [isl_pkg::DATA_W-1:0]        hess_xx,
	output logic [isl_pkg::DATA_W-1:0]        hess_yy,
	output logic [isl_pkg::DATA_W-1:0]        hess_xy,
	output logic                              at_center,
	output logic                              saturated,
	output logic                              last_out
);

	localparam int unsigned LAT = 3 + isl_pkg::ROOT_W + 1 + isl_pkg::QUO_W + 1
		+ isl_pkg::QUO_W + isl_pkg::HQUO_W + 1;

	// configuration
	logic [isl_pkg::B_W-1:0]    b_q;
	logic [isl_pkg::DATA_W-1:0] cx_q;
	logic [isl_pkg::DATA_W-1:0] cy_q;
	logic                       gonly_q;
	logic                       busy_q;
	logic                       accept;
	logic [LAT-1:0]             vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q     <= isl_pkg::EINSTEIN_RESET;
			cx_q    <= '0;
			cy_q    <= '0;
			gonly_q <= 1'b0;
			busy_q  <= 1'b1;
			vld_q   <= '0;
		end else begin
			busy_q <= 1'b0;
			vld_q  <= {vld_q[LAT-2:0], accept};
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					isl_pkg::REG_EINSTEIN:  b_q     <= cfg_data[isl_pkg::B_W-1:0];
					isl_pkg::REG_CENTER_X:  cx_q    <= cfg_data;
					isl_pkg::REG_CENTER_Y:  cy_q    <= cfg_data;
					isl_pkg::REG_GRAD_ONLY: gonly_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign accept    = start && !busy_q;
	assign done      = vld_q[LAT-1];

	// offset, clamp, magnitude
	isl_pkg::sum_t  ox;
	isl_pkg::sum_t  oy;
	isl_pkg::side_t side_in;
	isl_pkg::side_t side_s1;
	isl_pkg::side_t side_s2;
	isl_pkg::side_t side_s3;

	always_comb begin
		ox = isl_pkg::sub_clamp(pos_x, cx_q);
		oy = isl_pkg::sub_clamp(pos_y, cy_q);
		side_in = '0;
		side_in.acc[isl_pkg::ACC_POT] = acc_pot;
		side_in.acc[isl_pkg::ACC_GX]  = acc_grad_x;
		side_in.acc[isl_pkg::ACC_GY]  = acc_grad_y;
		side_in.acc[isl_pkg::ACC_HXX] = acc_hess_xx;
		side_in.acc[isl_pkg::ACC_HYY] = acc_hess_yy;
		side_in.acc[isl_pkg::ACC_HXY] = acc_hess_xy;
		side_in.dx_neg = ox.val[isl_pkg::DATA_W-1];
		side_in.dy_neg = oy.val[isl_pkg::DATA_W-1];
		side_in.sat    = ox.sat | oy.sat;
		side_in.last   = last_point;
		// -(-2^31) wraps to 2^31, correct as unsigned
		side_in.ax = ox.val[isl_pkg::DATA_W-1] ? (~ox.val + 1'b1) : ox.val;
		side_in.ay = oy.val[isl_pkg::DATA_W-1] ? (~oy.val + 1'b1) : oy.val;
	end

	logic [isl_pkg::SQ_W-1:0] sqx_s2;
	logic [isl_pkg::SQ_W-1:0] sqy_s2;
	logic [isl_pkg::SQ_W-1:0] rad_s3;

	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		side_s2 <= side_s1;
		sqx_s2  <= isl_pkg::SQ_W'(side_s1.ax) * isl_pkg::SQ_W'(side_s1.ax);
		sqy_s2  <= isl_pkg::SQ_W'(side_s1.ay) * isl_pkg::SQ_W'(side_s1.ay);
		side_s3 <= side_s2;
		rad_s3  <= sqx_s2 + sqy_s2;
	end

	// square root chain
	logic [isl_pkg::SQRT_REM_W-1:0] sq_rem  [isl_pkg::ROOT_W+1];
	logic [isl_pkg::ROOT_W-1:0]     sq_root [isl_pkg::ROOT_W+1];
	logic [isl_pkg::SQ_W-1:0]       sq_rad  [isl_pkg::ROOT_W+1];

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = rad_s3;

	for (genvar i = 0; i < isl_pkg::ROOT_W; i++) begin : g_sqrt
		isl_sqrt_cell u_cell (
			.clk    (clk),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.rad_i  (sq_rad[i]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1]),
			.rad_o  (sq_rad[i+1])
		);
	end

	logic [isl_pkg::SIDE_W-1:0] side_sq_v;
	isl_pkg::side_t             side_sq;

	isl_delay #(.W(isl_pkg::SIDE_W), .N(isl_pkg::ROOT_W)) u_dly_sqrt (
		.clk    (clk),
		.data_i (side_s3),
		.data_o (side_sq_v)
	);
	assign side_sq = side_sq_v;

	// b*r, b*|dx|, b*|dy|
	isl_pkg::side_t             side_nx4;
	isl_pkg::side_t             side_s4;
	logic [isl_pkg::PROD_W-1:0] potp;
	logic [isl_pkg::PROD_W-1:0] bx_s4;
	logic [isl_pkg::PROD_W-1:0] by_s4;
	logic [isl_pkg::ROOT_W-1:0] root;

	assign root = sq_root[isl_pkg::ROOT_W];
	assign potp = isl_pkg::PROD_W'(b_q) * isl_pkg::PROD_W'(root);

	always_comb begin
		side_nx4      = side_sq;
		side_nx4.r    = root;
		side_nx4.zero = (root == '0);
		side_nx4.pot  = potp[isl_pkg::PROD_W-1:isl_pkg::FRAC_W];
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_nx4;
		bx_s4   <= isl_pkg::PROD_W'(b_q) * isl_pkg::PROD_W'(side_sq.ax);
		by_s4   <= isl_pkg::PROD_W'(b_q) * isl_pkg::PROD_W'(side_sq.ay);
	end

	// gradient quotients, also the first Hessian step
	logic [isl_pkg::QUO_W-1:0] qa_x;
	logic [isl_pkg::QUO_W-1:0] qa_y;

	isl_div_chain #(.QW(isl_pkg::QUO_W)) u_div_gx (
		.clk   (clk),
		.rem_i (isl_pkg::REM_W'(bx_s4[isl_pkg::PROD_W-1:isl_pkg::QUO_W])),
		.dq_i  (bx_s4[isl_pkg::QUO_W-1:0]),
		.d_i   (side_s4.r),
		.q_o   (qa_x)
	);

	isl_div_chain #(.QW(isl_pkg::QUO_W)) u_div_gy (
		.clk   (clk),
		.rem_i (isl_pkg::REM_W'(by_s4[isl_pkg::PROD_W-1:isl_pkg::QUO_W])),
		.dq_i  (by_s4[isl_pkg::QUO_W-1:0]),
		.d_i   (side_s4.r),
		.q_o   (qa_y)
	);

	logic [isl_pkg::SIDE_W-1:0] side_da_v;
	isl_pkg::side_t             side_da;

	isl_delay #(.W(isl_pkg::SIDE_W), .N(isl_pkg::QUO_W)) u_dly_a (
		.clk    (clk),
		.data_i (side_s4),
		.data_o (side_da_v)
	);
	assign side_da = side_da_v;

	// u*|q|: xx uses gy*ay, yy gx*ax, xy gx*ay
	isl_pkg::side_t             side_nx5;
	isl_pkg::side_t             side_s5;
	logic [isl_pkg::PROD_W-1:0] pxx_s5;
	logic [isl_pkg::PROD_W-1:0] pyy_s5;
	logic [isl_pkg::PROD_W-1:0] pxy_s5;

	always_comb begin
		side_nx5    = side_da;
		side_nx5.gx = qa_x;
		side_nx5.gy = qa_y;
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_nx5;
		pxx_s5  <= isl_pkg::PROD_W'(qa_y) * isl_pkg::PROD_W'(side_da.ay);
		pyy_s5  <= isl_pkg::PROD_W'(qa_x) * isl_pkg::PROD_W'(side_da.ax);
		pxy_s5  <= isl_pkg::PROD_W'(qa_x) * isl_pkg::PROD_W'(side_da.ay);
	end

	logic [isl_pkg::QUO_W-1:0] vxx;
	logic [isl_pkg::QUO_W-1:0] vyy;
	logic [isl_pkg::QUO_W-1:0] vxy;

	isl_div_chain #(.QW(isl_pkg::QUO_W)) u_div_vxx (
		.clk   (clk),
		.rem_i (isl_pkg::REM_W'(pxx_s5[isl_pkg::PROD_W-1:isl_pkg::QUO_W])),
		.dq_i  (pxx_s5[isl_pkg::QUO_W-1:0]),
		.d_i   (side_s5.r),
		.q_o   (vxx)
	);

	isl_div_chain #(.QW(isl_pkg::QUO_W)) u_div_vyy (
		.clk   (clk),
		.rem_i (isl_pkg::REM_W'(pyy_s5[isl_pkg::PROD_W-1:isl_pkg::QUO_W])),
		.dq_i  (pyy_s5[isl_pkg::QUO_W-1:0]),
		.d_i   (side_s5.r),
		.q_o   (vyy)
	);

	isl_div_chain #(.QW(isl_pkg::QUO_W)) u_div_vxy (
		.clk   (clk),
		.rem_i (isl_pkg::REM_W'(pxy_s5[isl_pkg::PROD_W-1:isl_pkg::QUO_W])),
		.dq_i  (pxy_s5[isl_pkg::QUO_W-1:0]),
		.d_i   (side_s5.r),
		.q_o   (vxy)
	);

	logic [isl_pkg::SIDE_W-1:0] side_db_v;
	isl_pkg::side_t             side_db;

	isl_delay #(.W(isl_pkg::SIDE_W), .N(isl_pkg::QUO_W)) u_dly_b (
		.clk    (clk),
		.data_i (side_s5),
		.data_o (side_db_v)
	);
	assign side_db = side_db_v;

	// v*2^16 / r
	logic [isl_pkg::HQUO_W-1:0] wxx;
	logic [isl_pkg::HQUO_W-1:0] wyy;
	logic [isl_pkg::HQUO_W-1:0] wxy;

	isl_div_chain #(.QW(isl_pkg::HQUO_W)) u_div_wxx (
		.clk   (clk),
		.rem_i ('0),
		.dq_i  ({vxx, {isl_pkg::FRAC_W{1'b0}}}),
		.d_i   (side_db.r),
		.q_o   (wxx)
	);

	isl_div_chain #(.QW(isl_pkg::HQUO_W)) u_div_wyy (
		.clk   (clk),
		.rem_i ('0),
		.dq_i  ({vyy, {isl_pkg::FRAC_W{1'b0}}}),
		.d_i   (side_db.r),
		.q_o   (wyy)
	);

	isl_div_chain #(.QW(isl_pkg::HQUO_W)) u_div_wxy (
		.clk   (clk),
		.rem_i ('0),
		.dq_i  ({vxy, {isl_pkg::FRAC_W{1'b0}}}),
		.d_i   (side_db.r),
		.q_o   (wxy)
	);

	logic [isl_pkg::SIDE_W-1:0] side_dc_v;
	isl_pkg::side_t             side_dc;

	isl_delay #(.W(isl_pkg::SIDE_W), .N(isl_pkg::HQUO_W)) u_dly_c (
		.clk    (clk),
		.data_i (side_db),
		.data_o (side_dc_v)
	);
	assign side_dc = side_dc_v;

	// signed terms, saturating sums
	logic [isl_pkg::TERM_W-1:0] t_pot;
	logic [isl_pkg::TERM_W-1:0] t_gx;
	logic [isl_pkg::TERM_W-1:0] t_gy;
	logic [isl_pkg::TERM_W-1:0] t_hxx;
	logic [isl_pkg::TERM_W-1:0] t_hyy;
	logic [isl_pkg::TERM_W-1:0] t_hxy;
	isl_pkg::sum_t              s_pot;
	isl_pkg::sum_t              s_gx;
	isl_pkg::sum_t              s_gy;
	isl_pkg::sum_t              s_hxx;
	isl_pkg::sum_t              s_hyy;
	isl_pkg::sum_t              s_hxy;
	logic [isl_pkg::N_ACC-1:0][isl_pkg::DATA_W-1:0] res;
	logic                       res_sat;

	always_comb begin
		t_pot = isl_pkg::TERM_W'(side_dc.pot);
		t_gx  = isl_pkg::TERM_W'(side_dc.gx);
		t_gy  = isl_pkg::TERM_W'(side_dc.gy);
		t_hxx = isl_pkg::TERM_W'(wxx);
		t_hyy = isl_pkg::TERM_W'(wyy);
		t_hxy = isl_pkg::TERM_W'(wxy);
		if (side_dc.dx_neg) t_gx = -t_gx;
		if (side_dc.dy_neg) t_gy = -t_gy;
		if (side_dc.dx_neg == side_dc.dy_neg) t_hxy = -t_hxy;

		s_pot = isl_pkg::clamp_add(side_dc.acc[isl_pkg::ACC_POT], t_pot);
		s_gx  = isl_pkg::clamp_add(side_dc.acc[isl_pkg::ACC_GX], t_gx);
		s_gy  = isl_pkg::clamp_add(side_dc.acc[isl_pkg::ACC_GY], t_gy);
		s_hxx = isl_pkg::clamp_add(side_dc.acc[isl_pkg::ACC_HXX], t_hxx);
		s_hyy = isl_pkg::clamp_add(side_dc.acc[isl_pkg::ACC_HYY], t_hyy);
		s_hxy = isl_pkg::clamp_add(side_dc.acc[isl_pkg::ACC_HXY], t_hxy);

		res     = side_dc.acc;
		res_sat = side_dc.sat;
		if (!side_dc.zero) begin
			res[isl_pkg::ACC_GX] = s_gx.val;
			res[isl_pkg::ACC_GY] = s_gy.val;
			res_sat = res_sat | s_gx.sat | s_gy.sat;
			if (!gonly_q) begin
				res[isl_pkg::ACC_POT] = s_pot.val;
				res[isl_pkg::ACC_HXX] = s_hxx.val;
				res[isl_pkg::ACC_HYY] = s_hyy.val;
				res[isl_pkg::ACC_HXY] = s_hxy.val;
				res_sat = res_sat | s_pot.sat | s_hxx.sat | s_hyy.sat | s_hxy.sat;
			end
		end
	end

	logic [isl_pkg::N_ACC-1:0][isl_pkg::DATA_W-1:0] res_q;
	logic                                           center_q;
	logic                                           sat_q;
	logic                                           last_q;

	always_ff @(posedge clk) begin
		res_q    <= res;
		center_q <= side_dc.zero;
		sat_q    <= res_sat;
		last_q   <= side_dc.last;
	end

	assign pot       = res_q[isl_pkg::ACC_POT];
	assign grad_x    = res_q[isl_pkg::ACC_GX];
	assign grad_y    = res_q[isl_pkg::ACC_GY];
	assign hess_xx   = res_q[isl_pkg::ACC_HXX];
	assign hess_yy   = res_q[isl_pkg::ACC_HYY];
	assign hess_xy   = res_q[isl_pkg::ACC_HXY];
	assign at_center = center_q;
	assign saturated = sat_q;
	assign last_out  = last_q;

	// a clipped offset always gives a nonzero radius
	`ISL_ASSERT_IMPL(a_lat_fwd, accept, ##LAT done)
	`ISL_ASSERT_IMPL(a_lat_back, done, $past(accept, LAT))
	`ISL_ASSERT_IMPL(a_center_clean, done && at_center, !saturated)
	`ISL_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int LIMIT_CYCLES = 600000;
	localparam int LATENCY_WAIT = 160;
	localparam logic [isl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam logic [31:0] S_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S_MIN = 32'h8000_0000;

	typedef struct {
		logic [31:0] px, py;
		logic [31:0] acc [6];
		logic        last;
	} lens_word_t;

	typedef struct {
		logic [31:0] sums [6];
		logic        center, sat, last;
	} lens_sums_t;

	class lens_scoreboard;
		longint unsigned b_strength;
		longint          cx, cy;
		bit              grad_only;
		lens_sums_t      expected_q[$];
		int              mismatches, n_words, n_checked, n_center, n_sat;

		function new();
			b_strength = 65536;
			cx = 0;
			cy = 0;
			grad_only = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function longint clip32(longint v, inout bit sat);
			if (v > 64'sd2147483647) begin
				sat = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				sat = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n)
				bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		// b*p*q*2^16 / r^3 in three truncating divides
		function longint unsigned curv_mag(longint unsigned b, longint unsigned p,
			longint unsigned q, longint unsigned r);
			longint unsigned u, v;
			u = (b * p) / r;
			v = (u * q) / r;
			return (v << 16) / r;
		endfunction

		function void note_word(lens_word_t w);
			longint          dx, dy, s [6], t;
			longint unsigned ax, ay, r;
			bit              sat;
			lens_sums_t      e;
			sat = 0;
			for (int k = 0; k < 6; k++)
				s[k] = longint'($signed(w.acc[k]));
			dx = clip32(longint'($signed(w.px)) - cx, sat);
			dy = clip32(longint'($signed(w.py)) - cy, sat);
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			r = int_sqrt(ax * ax + ay * ay);
			e.center = (r == 0);
			if (r != 0) begin
				t = longint'((b_strength * ax) / r);
				s[isl_pkg::ACC_GX] = clip32(s[isl_pkg::ACC_GX] + (dx < 0 ? -t : t), sat);
				t = longint'((b_strength * ay) / r);
				s[isl_pkg::ACC_GY] = clip32(s[isl_pkg::ACC_GY] + (dy < 0 ? -t : t), sat);
				if (!grad_only) begin
					s[isl_pkg::ACC_POT] = clip32(s[isl_pkg::ACC_POT]
						+ longint'((b_strength * r) >> 16), sat);
					s[isl_pkg::ACC_HXX] = clip32(s[isl_pkg::ACC_HXX]
						+ longint'(curv_mag(b_strength, ay, ay, r)), sat);
					s[isl_pkg::ACC_HYY] = clip32(s[isl_pkg::ACC_HYY]
						+ longint'(curv_mag(b_strength, ax, ax, r)), sat);
					t = longint'(curv_mag(b_strength, ax, ay, r));
					s[isl_pkg::ACC_HXY] = clip32(s[isl_pkg::ACC_HXY]
						+ (((dx < 0) == (dy < 0)) ? -t : t), sat);
				end
			end
			for (int k = 0; k < 6; k++)
				e.sums[k] = s[k][31:0];
			e.sat = sat;
			e.last = w.last;
			n_words++;
			if (e.center) n_center++;
			if (sat) n_sat++;
			expected_q.push_back(e);
		endfunction

		function void field_cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on result %0d, %s: expected %h, got %h",
						n_checked, name, exp_v, act_v);
			end
		endfunction

		function void check_sums(lens_sums_t a);
			lens_sums_t e;
			string      names [6] = '{"pot", "grad_x", "grad_y", "hess_xx", "hess_yy",
				"hess_xy"};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word, nothing outstanding");
				return;
			end
			e = expected_q.pop_front();
			for (int k = 0; k < 6; k++)
				field_cmp(names[k], e.sums[k], a.sums[k]);
			field_cmp("at_center", 32'(e.center), 32'(a.center));
			field_cmp("saturated", 32'(e.sat), 32'(a.sat));
			field_cmp("last_out", 32'(e.last), 32'(a.last));
			n_checked++;
		endfunction
	endclass

	logic clk, arst_n;
	logic start, busy, last_point, cfg_valid, cfg_ready, done;
	logic [31:0] pos_x, pos_y, acc_pot, acc_grad_x, acc_grad_y;
	logic [31:0] acc_hess_xx, acc_hess_yy, acc_hess_xy, cfg_data;
	logic [isl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] pot, grad_x, grad_y, hess_xx, hess_yy, hess_xy;
	logic at_center, saturated, last_out;

	lens_scoreboard sums_board = new();
	int          cycles;
	logic [31:0] cur_cx, cur_cy;
	bit          allow_idle;

	isothermal_sphere_lens_terms i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .acc_pot(acc_pot), .acc_grad_x(acc_grad_x),
		.acc_grad_y(acc_grad_y), .acc_hess_xx(acc_hess_xx), .acc_hess_yy(acc_hess_yy),
		.acc_hess_xy(acc_hess_xy), .last_point(last_point),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .pot(pot), .grad_x(grad_x), .grad_y(grad_y),
		.hess_xx(hess_xx), .hess_yy(hess_yy), .hess_xy(hess_xy),
		.at_center(at_center), .saturated(saturated), .last_out(last_out)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		lens_sums_t a;
		if (arst_n && done) begin
			a.sums = '{pot, grad_x, grad_y, hess_xx, hess_yy, hess_xy};
			a.center = at_center;
			a.sat = saturated;
			a.last = last_out;
			sums_board.check_sums(a);
		end
	end

	// caller is at a rising edge; start stays high on return unless allow_idle drew an idle gap
	task automatic send_word(lens_word_t w);
		start <= 1;
		pos_x <= w.px;
		pos_y <= w.py;
		acc_pot <= w.acc[0];
		acc_grad_x <= w.acc[1];
		acc_grad_y <= w.acc[2];
		acc_hess_xx <= w.acc[3];
		acc_hess_yy <= w.acc[4];
		acc_hess_xy <= w.acc[5];
		last_point <= w.last;
		do @(posedge clk); while (busy);
		sums_board.note_word(w);
		if (allow_idle && $urandom_range(0, 5) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		while (sums_board.pending() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_regs(logic [30:0] b, logic [31:0] cx, logic [31:0] cy, bit go);
		logic [isl_pkg::CFG_IDX_W-1:0] idx [5] = '{isl_pkg::REG_EINSTEIN,
			isl_pkg::REG_CENTER_X, isl_pkg::REG_CENTER_Y, isl_pkg::REG_GRAD_ONLY,
			REG_UNUSED};
		logic [31:0] val [5];
		val = '{{1'b0, b}, cx, cy, {31'd0, go}, $urandom()};
		for (int k = 0; k < 5; k++) begin
			cfg_valid <= 1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 0;
		sums_board.b_strength = b;
		sums_board.cx = longint'($signed(cx));
		sums_board.cy = longint'($signed(cy));
		sums_board.grad_only = go;
		cur_cx = cx;
		cur_cy = cy;
	endtask

	function automatic logic [31:0] corner_val();
		case ($urandom_range(0, 3))
			0: return S_MAX;
			1: return S_MIN;
			2: return 32'd0;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic lens_word_t rand_word();
		lens_word_t w;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 3) begin
			w.px = cur_cx + 32'($signed($urandom_range(0, 8)) - 4);
			w.py = cur_cy + 32'($signed($urandom_range(0, 8)) - 4);
		end else if (mode < 5) begin
			w.px = cur_cx + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			w.py = cur_cy + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
		end else if (mode < 9) begin
			w.px = $urandom();
			w.py = $urandom();
		end else begin
			w.px = corner_val();
			w.py = corner_val();
		end
		for (int k = 0; k < 6; k++)
			w.acc[k] = ($urandom_range(0, 7) == 0) ? corner_val() : $urandom();
		w.last = $urandom_range(0, 1);
		return w;
	endfunction

	task automatic run_random(int n);
		repeat (n) send_word(rand_word());
	endtask

	initial begin
		lens_word_t w;
		logic [31:0] dir_pos [9][2] = '{
			'{32'd0, 32'd0}, '{32'd1, 32'd0}, '{32'd0, 32'd1}, '{32'hffff_ffff, 32'hffff_ffff},
			'{S_MAX, S_MAX}, '{S_MIN, S_MIN}, '{S_MIN, S_MAX}, '{32'h0001_0000, 32'hffff_0000},
			'{32'h0003_0000, 32'h0004_0000}};
		cycles = 0;
		arst_n = 0;
		start = 0;
		last_point = 0;
		pos_x = 0;
		pos_y = 0;
		acc_pot = 0;
		acc_grad_x = 0;
		acc_grad_y = 0;
		acc_hess_xx = 0;
		acc_hess_yy = 0;
		acc_hess_xy = 0;
		cfg_valid = 0;
		cfg_index = isl_pkg::REG_EINSTEIN;
		cfg_data = 0;
		cur_cx = 0;
		cur_cy = 0;
		allow_idle = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: zero radius, unit steps, extreme positions and sums
		for (int k = 0; k < 9; k++) begin
			w.px = dir_pos[k][0];
			w.py = dir_pos[k][1];
			for (int j = 0; j < 6; j++)
				w.acc[j] = (k % 3 == 0) ? S_MAX : (k % 3 == 1) ? S_MIN : 32'd0;
			w.last = k[0];
			send_word(w);
		end
		drain();

		// offset clipping with the strongest lens
		write_regs(31'h7fff_ffff, S_MAX, S_MIN, 0);
		for (int k = 0; k < 6; k++) begin
			w.px = corner_val();
			w.py = corner_val();
			for (int j = 0; j < 6; j++)
				w.acc[j] = corner_val();
			w.last = 1;
			send_word(w);
		end
		run_random(300);
		drain();

		write_regs(31'd0, S_MIN, S_MAX, 1);
		run_random(250);
		drain();

		write_regs(31'($urandom()), $urandom(), $urandom(), 1);
		run_random(350);
		drain();

		write_regs(31'($urandom_range(1, 1 << 22)), 32'($urandom_range(0, 1 << 20)),
			-32'($urandom_range(0, 1 << 20)), 0);
		run_random(400);
		drain();

		write_regs(31'($urandom()), $urandom(), $urandom(), 0);
		run_random(350);
		drain();

		// last stretch: back to back words, no gaps
		allow_idle = 0;
		write_regs(31'd65536, 32'd0, 32'd0, 0);
		run_random(350);
		drain();

		$display("covered %0d words, %0d checked; %0d at lens center, %0d saturated",
			sums_board.n_words, sums_board.n_checked, sums_board.n_center, sums_board.n_sat);
		$display("mismatches: %0d", sums_board.mismatches);
		if (sums_board.mismatches == 0 && sums_board.pending() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// File: isothermal_sphere_lens_terms.f
+incdir+rtl
rtl/isl_pkg.sv
rtl/isl_sqrt_cell.sv
rtl/isl_div_cell.sv
rtl/isl_div_chain.sv
rtl/isl_delay.sv
rtl/isothermal_sphere_lens_terms.sv
tb/tb_top.sv
